// File: hdl/matrix4x4_multiply_defines.svh
`ifndef MATRIX4X4_MULTIPLY_DEFINES_SVH
`define MATRIX4X4_MULTIPLY_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define MM4_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("matrix multiply check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define MM4_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("matrix multiply check failed");

`endif

// File: hdl/mm4_pkg.sv
`timescale 1ns / 1ps

package mm4_pkg;

  localparam int unsigned DIM_DEF       = 4;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned IDX_W  = 2;

  localparam logic signed [ELEM_W-1:0] PROD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ELEM_W-1:0] PROD_MIN = 32'sh8000_0000;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic        [IDX_W-1:0]  idx_t;

  typedef struct packed {
    logic vld;
    logic clr;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
  } mac_stat_t;

endpackage

// File: hdl/mm4_stream_if.sv
`timescale 1ns / 1ps

interface mm4_elem_if import mm4_pkg::*; ();
  logic  valid;
  logic  ready;
  elem_t element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface mm4_prod_if import mm4_pkg::*; ();
  logic  valid;
  logic  ready;
  elem_t product;
  idx_t  row;
  idx_t  col;
  logic  clipped;
  logic  last;

  modport source (output valid, output product, output row, output col, output clipped,
                  output last, input ready);
  modport sink   (input valid, input product, input row, input col, input clipped,
                  input last, output ready);
endinterface

// File: hdl/matrix4x4_multiply.sv
`timescale 1ns / 1ps

// DIM x DIM fixed-point matrix multiplier, signed Q16.16 by default.
// elem_i: valid/ready input beats, one element each. The first DIM*DIM beats
//   are the left matrix, the next DIM*DIM the right one, both column-major.
// prod_o: valid/ready output beats, DIM*DIM per matrix pair, column-major,
//   with row/col indices, a saturation flag and last on the final element.
// Loading accepts one beat per clock while ready is high. After the final beat
// ready drops and one multiplier steps through the DIM products of each
// element: it issues the DIM reads, empties the read and multiply stages, and
// then shifts down and saturates the sum into the output register, one product
// at a time, as each store has a single read port and there is one multiplier.
// Ready rises again as the last product enters the output register.
// A receiver stall holds the output register; the sequencer goes on to the
// next element and waits in its final step until the pending beat is taken.
// Reset returns the block to loading with an empty output; the stores keep
// their contents and are rewritten by every load.
module matrix4x4_multiply import mm4_pkg::*; #(
  parameter int unsigned DIM       = DIM_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mm4_elem_if.sink   elem_i,
  mm4_prod_if.source prod_o
);

  localparam int unsigned CELLS  = DIM * DIM;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned CNT_W  = $clog2(2 * CELLS);
  localparam int unsigned K_W    = $clog2(DIM);
  localparam int unsigned ACC_W  = 2 * ELEM_W + $clog2(DIM);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_CALC  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_e;

  state_e             state_d, state_q;
  logic [CNT_W-1:0]   cnt_d, cnt_q;
  logic [K_W-1:0]     i_d, i_q, j_d, j_q, k_d, k_q;
  logic [ADDR_W-1:0]  l_addr_d, l_addr_q, r_addr_d, r_addr_q, r_base_d, r_base_q;
  logic               rd_vld_q;
  logic               out_vld_d, out_vld_q;

  elem_t              left_mem  [CELLS];
  elem_t              right_mem [CELLS];
  elem_t              l_rd_q, r_rd_q;

  elem_t              prod_q;
  idx_t               row_q, col_q;
  logic               clip_q, last_q;

  logic               in_beat, out_beat, out_free, last_load, is_right;
  logic               i_last, j_last, k_last, cell_done;
  logic [ADDR_W-1:0]  waddr;

  mac_ctrl_t               mac_ctrl;
  mac_stat_t               mac_stat;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] shifted;
  logic                    fits;
  elem_t                   sat_val;

  assign elem_i.ready = (state_q == ST_LOAD);
  assign in_beat      = elem_i.valid && elem_i.ready;
  assign out_beat     = out_vld_q && prod_o.ready;
  assign out_free     = !out_vld_q || prod_o.ready;
  assign last_load    = (cnt_q == CNT_W'(2 * CELLS - 1));
  assign is_right     = (cnt_q >= CNT_W'(CELLS));
  assign waddr        = is_right ? ADDR_W'(cnt_q - CNT_W'(CELLS)) : ADDR_W'(cnt_q);
  assign i_last       = (i_q == K_W'(DIM - 1));
  assign j_last       = (j_q == K_W'(DIM - 1));
  assign k_last       = (k_q == K_W'(DIM - 1));
  assign cell_done    = (state_q == ST_FIN) && out_free;

  // Store writes and registered reads
  always_ff @(posedge clk_i) begin
    if (in_beat && !is_right) begin
      left_mem[waddr] <= elem_i.element;
    end
    if (in_beat && is_right) begin
      right_mem[waddr] <= elem_i.element;
    end
    l_rd_q <= left_mem[l_addr_q];
    r_rd_q <= right_mem[r_addr_q];
  end

  assign mac_ctrl.vld = rd_vld_q;
  assign mac_ctrl.clr = (state_q == ST_LOAD) || cell_done;

  mm4_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (l_rd_q),
    .b_i    (r_rd_q),
    .acc_o  (acc),
    .stat_o (mac_stat)
  );

  // Drop fractional bits, then saturate
  always_comb begin
    shifted = acc >>> FRAC_BITS;
    fits    = (&shifted[ACC_W-1:ELEM_W-1]) || !(|shifted[ACC_W-1:ELEM_W-1]);
    if (fits) begin
      sat_val = shifted[ELEM_W-1:0];
    end else if (acc[ACC_W-1]) begin
      sat_val = PROD_MIN;
    end else begin
      sat_val = PROD_MAX;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    l_addr_d  = l_addr_q;
    r_addr_d  = r_addr_q;
    r_base_d  = r_base_q;
    out_vld_d = out_beat ? 1'b0 : out_vld_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_beat) begin
          if (last_load) begin
            cnt_d    = '0;
            i_d      = '0;
            j_d      = '0;
            k_d      = '0;
            l_addr_d = '0;
            r_addr_d = '0;
            r_base_d = '0;
            state_d  = ST_CALC;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_CALC: begin
        k_d      = k_q + 1'b1;
        l_addr_d = l_addr_q + ADDR_W'(DIM);
        r_addr_d = r_addr_q + 1'b1;
        if (k_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !mac_stat.busy) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          k_d       = '0;
          if (i_last && j_last) begin
            state_d = ST_LOAD;
          end else if (i_last) begin
            i_d      = '0;
            j_d      = j_q + 1'b1;
            r_base_d = r_base_q + ADDR_W'(DIM);
            l_addr_d = '0;
            r_addr_d = r_base_q + ADDR_W'(DIM);
            state_d  = ST_CALC;
          end else begin
            i_d      = i_q + 1'b1;
            l_addr_d = ADDR_W'(i_q) + 1'b1;
            r_addr_d = r_base_q;
            state_d  = ST_CALC;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      cnt_q     <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      l_addr_q  <= '0;
      r_addr_q  <= '0;
      r_base_q  <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
      l_addr_q  <= l_addr_d;
      r_addr_q  <= r_addr_d;
      r_base_q  <= r_base_d;
      rd_vld_q  <= (state_q == ST_CALC);
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_done) begin
      prod_q <= sat_val;
      row_q  <= IDX_W'(i_q);
      col_q  <= IDX_W'(j_q);
      clip_q <= !fits;
      last_q <= i_last && j_last;
    end
  end

  assign prod_o.valid   = out_vld_q;
  assign prod_o.product = prod_q;
  assign prod_o.row     = row_q;
  assign prod_o.col     = col_q;
  assign prod_o.clipped = clip_q;
  assign prod_o.last    = last_q;

endmodule

// File: hdl/mm4_mac.sv
`timescale 1ns / 1ps

module mm4_mac import mm4_pkg::*; #(
  parameter int unsigned ACC_W = 2 * ELEM_W + 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_ctrl_t               ctrl_i,
  input  elem_t                   a_i,
  input  elem_t                   b_i,
  output logic signed [ACC_W-1:0] acc_o,
  output mac_stat_t               stat_o
);

  logic signed [2*ELEM_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]    acc_d, acc_q;
  logic                       pvld_q;

  always_comb begin
    prod_d = a_i * b_i;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (pvld_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q <= 1'b0;
    end else begin
      pvld_q <= ctrl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o       = acc_q;
  assign stat_o.busy = pvld_q;

endmodule

// File: hdl/matrix4x4_multiply_checker.sv
`timescale 1ns / 1ps

`include "matrix4x4_multiply_defines.svh"

module matrix4x4_multiply_checker import mm4_pkg::*; (
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_ready_i,
  input logic  out_valid_i,
  input logic  out_ready_i,
  input elem_t out_product_i,
  input idx_t  out_row_i,
  input idx_t  out_col_i,
  input logic  out_clipped_i,
  input logic  out_last_i
);

  logic out_stall, out_beat;

  assign out_stall = out_valid_i && !out_ready_i;
  assign out_beat  = out_valid_i && out_ready_i;

  // Hold a stalled beat
  `MM4_ASSERT_NEXT(a_stall_hold, out_stall,
    out_valid_i && $stable(out_product_i) && $stable(out_clipped_i) && $stable(out_last_i))

  // No loading while a matrix is still being produced
  `MM4_ASSERT_NOW(a_no_load_mid_output, out_beat && !out_last_i, !in_ready_i)

  // A clipped result is a rail value
  `MM4_ASSERT_NOW(a_clip_rail, out_valid_i && out_clipped_i,
    (out_product_i == PROD_MAX) || (out_product_i == PROD_MIN))

  // The final element sits on the diagonal
  `MM4_ASSERT_NOW(a_last_diag, out_valid_i && out_last_i, out_row_i == out_col_i)

endmodule

bind matrix4x4_multiply matrix4x4_multiply_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (elem_i.ready),
  .out_valid_i   (prod_o.valid),
  .out_ready_i   (prod_o.ready),
  .out_product_i (prod_o.product),
  .out_row_i     (prod_o.row),
  .out_col_i     (prod_o.col),
  .out_clipped_i (prod_o.clipped),
  .out_last_i    (prod_o.last)
);
